[design/mvt_pkg.sv]
// Shared types and constants of the matrix-vector transform block.
package mvt_pkg;

  localparam int WORD_W        = 32;
  localparam int DIM_W         = 3;
  localparam int IDX_W         = 4;
  localparam int NUM_LANES     = 4;
  localparam int MIN_DIM       = 2;
  localparam int DEF_MAX_DIM   = 4;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [NUM_LANES-1:0] vec_t;
  typedef vec_t [NUM_LANES-1:0] mat_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_XFORM = 1'b1
  } func_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    word_t            value;
  } load_t;

endpackage

[design/mvt_intf.sv]
// Valid/ready channel interfaces for input items, result items and configuration.
interface mvt_in_if import mvt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] elem_index;
  word_t            elem_value;
  word_t            vec_x;
  word_t            vec_y;
  word_t            vec_z;
  word_t            vec_w;

  modport source (
    output valid, func, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
    input  ready
  );
  modport sink (
    input  valid, func, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
    output ready
  );
endinterface

interface mvt_out_if import mvt_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t res_0;
  word_t res_1;
  word_t res_2;
  word_t res_3;
  logic  overflow;

  modport source (
    output valid, res_0, res_1, res_2, res_3, overflow,
    input  ready
  );
  modport sink (
    input  valid, res_0, res_1, res_2, res_3, overflow,
    output ready
  );
endinterface

interface mvt_cfg_if import mvt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] dim;

  modport source (
    output valid, dim,
    input  ready
  );
  modport sink (
    input  valid, dim,
    output ready
  );
endinterface

[design/matrix_vector_transform.sv]
// Top level of the matrix-vector transform block.
// Keeps a square matrix of size 2, 3 or 4 (config register dim, reset 4) in column-major
// order, element at column*dim+row, signed Q16.16, all zero after reset with no clearing
// pass. A load item writes one element in the cycle it is accepted and gives no result.
// A transform item gives one result: matrix times vector, each row sum rounded to nearest
// (ties up) and saturated to 32 bits, with overflow set on any saturation; components at or
// above dim read zero. The block takes one item per cycle while input ready is high; a
// transform result reaches the output through five register stages (operand select,
// sixteen 32x32 multipliers, pair adds, final add with rounding, saturate). Input ready
// falls only when the output is stalled and every stage holds an item.
module matrix_vector_transform import mvt_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input logic        clk_i,
  input logic        rst_ni,
  mvt_in_if.sink     in_if,
  mvt_out_if.source  out_if,
  mvt_cfg_if.sink    cfg_if
);

  logic  in_acc;
  logic  start;
  load_t load;
  mat_t  opnd;
  vec_t  vec;
  vec_t  res;
  logic  in_ready;
  logic  out_valid;
  logic  ovf;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_ready;
  assign start        = in_acc && (in_if.func == FUNC_XFORM);

  assign load.en    = in_acc && (in_if.func == FUNC_LOAD);
  assign load.index = in_if.elem_index;
  assign load.value = in_if.elem_value;

  assign vec[0] = in_if.vec_x;
  assign vec[1] = in_if.vec_y;
  assign vec[2] = in_if.vec_z;
  assign vec[3] = in_if.vec_w;

  mvt_store #(
    .MAX_DIM (MAX_DIM)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_if.valid),
    .cfg_dim_i   (cfg_if.dim),
    .load_i      (load),
    .opnd_o      (opnd)
  );

  mvt_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .opnd_i      (opnd),
    .vec_i       (vec),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .res_o       (res),
    .ovf_o       (ovf)
  );

  assign out_if.valid    = out_valid;
  assign out_if.res_0    = res[0];
  assign out_if.res_1    = res[1];
  assign out_if.res_2    = res[2];
  assign out_if.res_3    = res[3];
  assign out_if.overflow = ovf;

endmodule

[design/mvt_store.sv]
// Matrix element store, size register and operand selection for the current size.
module mvt_store import mvt_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [DIM_W-1:0] cfg_dim_i,
  input  load_t            load_i,
  output mat_t             opnd_o
);

  localparam int LANES = (MAX_DIM < NUM_LANES) ? MAX_DIM : NUM_LANES;
  localparam int DEPTH = LANES * LANES;
  localparam int IW    = $clog2(DEPTH);

  logic [DIM_W-1:0]  dim_q;
  logic [DIM_W-1:0]  dim_eff;
  logic [WORD_W-1:0] store_q [DEPTH];
  logic              wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RESET;
    end else if (cfg_valid_i) begin
      dim_q <= cfg_dim_i;
    end
  end

  assign wr_en = load_i.en && ({1'b0, load_i.index} < (IDX_W+1)'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (wr_en) begin
      store_q[load_i.index[IW-1:0]] <= load_i.value;
    end
  end

  always_comb begin
    if (dim_q < DIM_W'(MIN_DIM)) begin
      dim_eff = DIM_W'(MIN_DIM);
    end else if (dim_q > DIM_W'(LANES)) begin
      dim_eff = DIM_W'(LANES);
    end else begin
      dim_eff = dim_q;
    end
  end

  // zero every element outside the active size so its products vanish
  always_comb begin
    opnd_o = '0;
    for (int c = 0; c < NUM_LANES; c++) begin
      for (int r = 0; r < NUM_LANES; r++) begin
        for (int dv = MIN_DIM; dv <= LANES; dv++) begin
          if (dim_eff == DIM_W'(dv) && c < dv && r < dv) begin
            opnd_o[c][r] = store_q[IW'(c * dv + r)];
          end
        end
      end
    end
  end

endmodule

[design/mvt_datapath.sv]
// Pipelined multiply, add tree, rounding and saturation with stall handling.
module mvt_datapath import mvt_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  mat_t  opnd_i,
  input  vec_t  vec_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output vec_t  res_o,
  output logic  ovf_o
);

  localparam int PROD_W = 2 * WORD_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'((66'd1 << FRAC_BITS) >> 1);
  localparam logic signed [SUM_W-1:0] RES_MAX = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] RES_MIN = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, eno;

  logic signed [WORD_W-1:0] a1_q [NUM_LANES][NUM_LANES];
  logic signed [WORD_W-1:0] x1_q [NUM_LANES];
  logic signed [PROD_W-1:0] p2_q [NUM_LANES][NUM_LANES];
  logic signed [PROD_W-1:0] p2_d [NUM_LANES][NUM_LANES];
  logic signed [PAIR_W-1:0] s3_q [NUM_LANES][2];
  logic signed [PAIR_W-1:0] s3_d [NUM_LANES][2];
  logic signed [SUM_W-1:0]  t4_q [NUM_LANES];
  logic signed [SUM_W-1:0]  t4_d [NUM_LANES];
  logic signed [SUM_W-1:0]  q4   [NUM_LANES];
  logic signed [WORD_W-1:0] res_d [NUM_LANES];
  logic signed [WORD_W-1:0] res_q [NUM_LANES];
  logic [NUM_LANES-1:0]     sat_d;
  logic                     ovf_q;

  always_comb begin
    eno = !vo_q || out_ready_i;
    en4 = !v4_q || eno;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
  end

  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= start_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (eno) vo_q <= v4_q;
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_LANES; r++) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        p2_d[r][c] = PROD_W'(a1_q[r][c]) * PROD_W'(x1_q[c]);
      end
      s3_d[r][0] = PAIR_W'(p2_q[r][0]) + PAIR_W'(p2_q[r][1]);
      s3_d[r][1] = PAIR_W'(p2_q[r][2]) + PAIR_W'(p2_q[r][3]);
      t4_d[r]    = SUM_W'(s3_q[r][0]) + SUM_W'(s3_q[r][1]) + ROUND;
      q4[r]      = t4_q[r] >>> FRAC_BITS;
      if (q4[r] > RES_MAX) begin
        res_d[r] = RES_MAX[WORD_W-1:0];
        sat_d[r] = 1'b1;
      end else if (q4[r] < RES_MIN) begin
        res_d[r] = RES_MIN[WORD_W-1:0];
        sat_d[r] = 1'b1;
      end else begin
        res_d[r] = q4[r][WORD_W-1:0];
        sat_d[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        x1_q[c] <= $signed(vec_i[c]);
        for (int r = 0; r < NUM_LANES; r++) begin
          a1_q[r][c] <= $signed(opnd_i[c][r]);
        end
      end
    end
    if (en2) begin
      p2_q <= p2_d;
    end
    if (en3) begin
      s3_q <= s3_d;
    end
    if (en4) begin
      t4_q <= t4_d;
    end
    if (eno) begin
      res_q <= res_d;
      ovf_q <= |sat_d;
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_LANES; r++) begin
      res_o[r] = res_q[r];
    end
  end

  assign out_valid_o = vo_q;
  assign ovf_o       = ovf_q;

endmodule
